// ===== rtl/core/fxalu_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Opcodes, item classes and the work record passed from front to back.
// ----------------------------------------------------------------------------
package fxalu_pkg;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_GT   = 4'd4,
        OP_LT   = 4'd5,
        OP_GE   = 4'd6,
        OP_LE   = 4'd7,
        OP_EQ   = 4'd8,
        OP_NE   = 4'd9,
        OP_MIN  = 4'd10,
        OP_MAX  = 4'd11,
        OP_FINT = 4'd12,
        OP_TINT = 4'd13,
        OP_INC  = 4'd14,
        OP_DEC  = 4'd15
    } t_op;

    typedef enum logic [1:0] {
        K_SIMPLE,
        K_MUL,
        K_DIV
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] res;
        logic        flag;
        logic        dz;
        logic        neg;
        logic [31:0] opa;
        logic [31:0] opb;
    } t_work;

endpackage

// ===== rtl/core/fxalu_if.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU channels
// Request and result channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface fxalu_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         op;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, output op, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input op, input operand_a, input operand_b,
                    output ready);
endinterface

interface fxalu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic               flag;
    logic               div_zero;

    modport source (output valid, output result, output flag, output div_zero,
                    input ready);
    modport sink   (input valid, input result, input flag, input div_zero,
                    output ready);
endinterface

// ===== rtl/core/fxalu_front.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU front end
// Accepts requests, evaluates the simple operations and prepares operands
// for the multiplier and the divider.
// ----------------------------------------------------------------------------
module fxalu_front #(
    parameter int FRAC_BITS = 8
) (
    fxalu_in_if.sink         i_in,
    input  logic             i_full,
    output logic             o_push,
    output fxalu_pkg::t_work o_work
);
    import fxalu_pkg::*;

    logic signed [31:0] w_a;
    logic signed [31:0] w_b;

    assign w_a = i_in.operand_a;
    assign w_b = i_in.operand_b;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_work      = '0;
        o_work.kind = K_SIMPLE;
        o_work.neg  = w_a[31] ^ w_b[31];
        o_work.opa  = w_a;
        o_work.opb  = w_b;
        unique case (t_op'(i_in.op))
            OP_ADD:  o_work.res = w_a + w_b;
            OP_SUB:  o_work.res = w_a - w_b;
            OP_MUL:  o_work.kind = K_MUL;
            OP_DIV: begin
                o_work.kind = K_DIV;
                o_work.dz   = (w_b == 32'sd0);
                o_work.opa  = w_a[31] ? 32'(-w_a) : w_a;
                o_work.opb  = w_b[31] ? 32'(-w_b) : w_b;
            end
            OP_GT:   o_work.flag = w_a > w_b;
            OP_LT:   o_work.flag = w_a < w_b;
            OP_GE:   o_work.flag = w_a >= w_b;
            OP_LE:   o_work.flag = w_a <= w_b;
            OP_EQ:   o_work.flag = w_a == w_b;
            OP_NE:   o_work.flag = w_a != w_b;
            OP_MIN:  o_work.res = (w_a < w_b) ? w_a : w_b;
            OP_MAX:  o_work.res = (w_a > w_b) ? w_a : w_b;
            OP_FINT: o_work.res = w_a << FRAC_BITS;
            OP_TINT: o_work.res = w_a >>> FRAC_BITS;
            OP_INC:  o_work.res = w_a + 32'sd1;
            OP_DEC:  o_work.res = w_a - 32'sd1;
            default: o_work.res = '0;
        endcase
    end

endmodule

// ===== rtl/core/fxalu_queue.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU work queue
// Two-entry queue that decouples the front end from the execution pipeline.
// ----------------------------------------------------------------------------
module fxalu_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fxalu_pkg::t_work i_data,
    output logic             o_full,
    input  logic             i_pop,
    output fxalu_pkg::t_work o_data,
    output logic             o_empty
);
    import fxalu_pkg::*;

    t_work       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_count;
    logic [1:0]  n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from an empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("queue count out of range");

endmodule

// ===== rtl/core/fxalu_back.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU execution pipeline
// Multiplier and a one-bit-per-stage restoring divider in a single
// stall-together pipeline, ending in the output register.
// ----------------------------------------------------------------------------
module fxalu_back #(
    parameter int FRAC_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  fxalu_pkg::t_work i_work,
    output logic             o_pop,
    fxalu_out_if.source      o_out
);
    import fxalu_pkg::*;

    localparam int DW = 32 + FRAC_BITS;
    localparam int NS = DW;

    logic               r_v    [NS+1];
    t_kind              r_kind [NS+1];
    logic [31:0]        r_res  [NS+1];
    logic               r_flag [NS+1];
    logic               r_dz   [NS+1];
    logic               r_neg  [NS+1];
    logic [31:0]        r_d    [NS+1];
    logic [31:0]        r_rem  [NS+1];
    logic [DW-1:0]      r_dq   [NS+1];
    logic signed [63:0] r_prod;

    logic [32:0]        w_t    [NS];
    logic [32:0]        w_s    [NS];
    logic               w_ge   [NS];
    logic [31:0]        n_rem  [NS];
    logic [DW-1:0]      n_dq   [NS];

    logic               r_o_valid;
    logic [31:0]        r_o_res;
    logic               r_o_flag;
    logic               r_o_dz;
    logic [31:0]        n_o_res;
    logic [31:0]        w_q;
    logic               w_adv;

    assign w_adv = !r_o_valid || o_out.ready;
    assign o_pop = w_adv && !i_empty;

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            w_t[k]   = {r_rem[k], r_dq[k][DW-1]};
            w_s[k]   = w_t[k] - {1'b0, r_d[k]};
            w_ge[k]  = (w_t[k] >= {1'b0, r_d[k]});
            n_rem[k] = w_ge[k] ? w_s[k][31:0] : w_t[k][31:0];
            n_dq[k]  = {r_dq[k][DW-2:0], w_ge[k]};
        end
    end

    assign w_q = r_dq[NS][31:0];

    always_comb begin
        n_o_res = r_res[NS];
        unique case (r_kind[NS])
            K_SIMPLE: n_o_res = r_res[NS];
            K_MUL:    n_o_res = r_res[NS];
            K_DIV:    n_o_res = r_dz[NS] ? 32'd0 : (r_neg[NS] ? -w_q : w_q);
            default:  n_o_res = r_res[NS];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) begin
                r_v[k] <= 1'b0;
            end
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= !i_empty;
            for (int k = 0; k < NS; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_o_valid <= r_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_kind[0] <= i_work.kind;
            r_res[0]  <= i_work.res;
            r_flag[0] <= i_work.flag;
            r_dz[0]   <= i_work.dz;
            r_neg[0]  <= i_work.neg;
            r_d[0]    <= i_work.opb;
            r_rem[0]  <= '0;
            r_dq[0]   <= {i_work.opa, {FRAC_BITS{1'b0}}};
            r_prod    <= $signed(i_work.opa) * $signed(i_work.opb);
            for (int k = 0; k < NS; k++) begin
                r_kind[k+1] <= r_kind[k];
                r_flag[k+1] <= r_flag[k];
                r_dz[k+1]   <= r_dz[k];
                r_neg[k+1]  <= r_neg[k];
                r_d[k+1]    <= r_d[k];
                r_rem[k+1]  <= n_rem[k];
                r_dq[k+1]   <= n_dq[k];
                if (k == 0) begin
                    r_res[k+1] <= (r_kind[k] == K_MUL) ? r_prod[FRAC_BITS +: 32]
                                                       : r_res[k];
                end else begin
                    r_res[k+1] <= r_res[k];
                end
            end
            r_o_res  <= n_o_res;
            r_o_flag <= r_flag[NS];
            r_o_dz   <= r_dz[NS];
        end
    end

    assign o_out.valid    = r_o_valid;
    assign o_out.result   = r_o_res;
    assign o_out.flag     = r_o_flag;
    assign o_out.div_zero = r_o_dz;

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_dz |-> r_o_res == 32'd0 && !r_o_flag)
        else $error("divide by zero result not cleared");
    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_flag |-> r_o_res == 32'd0)
        else $error("comparison carries a non-zero result");
    a_pop_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_v[0])
        else $error("popped request lost at pipeline entry");

endmodule

// ===== rtl/core/fixed_point_alu_q24_8.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU, signed Q24.8
// Every request, whatever its operation, passes through the queue, the
// one-bit-per-stage divider pipeline and the output register.
// Throughput is one request per cycle while the output channel is ready; the whole pipeline stalls together.
// Reset clears the queue and all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 #(
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fxalu_in_if.sink    i_in,
    fxalu_out_if.source o_out
);
    import fxalu_pkg::*;

    logic  w_full;
    logic  w_push;
    logic  w_pop;
    logic  w_empty;
    t_work w_front_work;
    t_work w_queue_work;

    fxalu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_work (w_front_work)
    );

    fxalu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_work),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_queue_work),
        .o_empty (w_empty)
    );

    fxalu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_work  (w_queue_work),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

// ===== verif/fixed_point_alu_q24_8_tb.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives requests through the input channel and checks every result against a
// bit-accurate prediction of the Q24.8 operations. Both channels idle at
// random, apart from one calm stretch.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8_tb;
    import fxalu_pkg::*;

    localparam int FRAC = 8;

    typedef struct packed {
        logic [31:0] res;
        logic        flag;
        logic        dz;
    } alu_out_t;

    typedef struct packed {
        t_op         op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

    logic i_clk;
    logic i_rst_n;

    fxalu_in_if  in_ch ();
    fxalu_out_if out_ch ();

    fixed_point_alu_q24_8 i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    alu_req_t pending_reqs[$];
    alu_out_t awaited_results[$];
    logic     req_taken;
    int       cyc;
    int       n_sent;
    int       n_checked;
    int       n_errors;
    bit       calm;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic alu_out_t compute_alu(t_op op, logic signed [31:0] a,
                                             logic signed [31:0] b);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] wide;
        logic [63:0]        ma;
        logic [63:0]        mb;
        logic [63:0]        quo;
        alu_out_t           r;
        wa = a;
        wb = b;
        r  = '0;
        case (op)
            OP_ADD: r.res = a + b;
            OP_SUB: r.res = a - b;
            OP_MUL: begin
                wide  = (wa * wb) >>> FRAC;
                r.res = wide[31:0];
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    ma    = (wa < 0) ? -wa : wa;
                    mb    = (wb < 0) ? -wb : wb;
                    quo   = (ma << FRAC) / mb;
                    if ((a < 0) != (b < 0)) quo = -quo;
                    r.res = quo[31:0];
                end
            end
            OP_GT:   r.flag = a > b;
            OP_LT:   r.flag = a < b;
            OP_GE:   r.flag = a >= b;
            OP_LE:   r.flag = a <= b;
            OP_EQ:   r.flag = a == b;
            OP_NE:   r.flag = a != b;
            OP_MIN:  r.res = (a < b) ? a : b;
            OP_MAX:  r.res = (a > b) ? a : b;
            OP_FINT: r.res = a <<< FRAC;
            OP_TINT: r.res = a >>> FRAC;
            OP_INC:  r.res = a + 1;
            default: r.res = a - 1;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            1: return $urandom_range(1024) - 512;
            2: return {$urandom_range(1) ? 24'hffffff : 24'h0, 8'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        req_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            awaited_results.push_back(compute_alu(t_op'(in_ch.op), in_ch.operand_a,
                                                  in_ch.operand_b));
            n_sent++;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result %h flag %b dz %b", $time,
                         out_ch.result, out_ch.flag, out_ch.div_zero);
                n_errors++;
            end else begin
                alu_out_t exp_r;
                exp_r = awaited_results.pop_front();
                if (exp_r.res !== out_ch.result || exp_r.flag !== out_ch.flag
                        || exp_r.dz !== out_ch.div_zero) begin
                    $display("%0t: expected %h/%b/%b, got %h/%b/%b", $time,
                             exp_r.res, exp_r.flag, exp_r.dz, out_ch.result,
                             out_ch.flag, out_ch.div_zero);
                    n_errors++;
                end
                n_checked++;
            end
        end
    end

    always @(negedge i_clk) begin
        calm = (cyc >= 700) && (cyc < 1200);
        out_ch.ready <= calm || ($urandom_range(99) >= 35);
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !req_taken) begin
            in_ch.valid <= 1'b1;
        end else if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 35)) begin
            alu_req_t nxt;
            nxt = pending_reqs.pop_front();
            in_ch.op        <= nxt.op;
            in_ch.operand_a <= nxt.a;
            in_ch.operand_b <= nxt.b;
            in_ch.valid     <= 1'b1;
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    task automatic wait_all_done();
        do begin
            @(negedge i_clk);
            #1;
        end while (pending_reqs.size() != 0 || (in_ch.valid && !req_taken)
                   || awaited_results.size() != 0);
    endtask

    initial begin
        logic [31:0] ra;
        cyc = 0;
        n_sent = 0;
        n_checked = 0;
        n_errors = 0;
        req_taken = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_ADD;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        pending_reqs.push_back('{OP_ADD, 32'h7fff_ffff, 32'h0000_0001});
        pending_reqs.push_back('{OP_SUB, 32'h8000_0000, 32'h0000_0001});
        pending_reqs.push_back('{OP_MUL, 32'h8000_0000, 32'h8000_0000});
        pending_reqs.push_back('{OP_MUL, 32'hffff_ff80, 32'h0000_0180});
        pending_reqs.push_back('{OP_DIV, 32'h0000_0500, 32'h0000_0000});
        pending_reqs.push_back('{OP_DIV, 32'h8000_0000, 32'hffff_ffff});
        pending_reqs.push_back('{OP_DIV, 32'hffff_fd00, 32'h0000_0200});
        pending_reqs.push_back('{OP_GT, 32'h8000_0000, 32'h7fff_ffff});
        pending_reqs.push_back('{OP_LT, 32'h8000_0000, 32'h7fff_ffff});
        pending_reqs.push_back('{OP_GE, 32'h0000_0100, 32'h0000_0100});
        pending_reqs.push_back('{OP_LE, 32'h7fff_ffff, 32'h8000_0000});
        pending_reqs.push_back('{OP_EQ, 32'hffff_ffff, 32'hffff_ffff});
        pending_reqs.push_back('{OP_NE, 32'hffff_ffff, 32'hffff_ffff});
        pending_reqs.push_back('{OP_MIN, 32'h0000_0042, 32'h0000_0042});
        pending_reqs.push_back('{OP_MIN, 32'h8000_0000, 32'h7fff_ffff});
        pending_reqs.push_back('{OP_MAX, 32'h0000_0042, 32'h0000_0042});
        pending_reqs.push_back('{OP_MAX, 32'h8000_0000, 32'h7fff_ffff});
        pending_reqs.push_back('{OP_FINT, 32'h7fff_ffff, 32'hffff_ffff});
        pending_reqs.push_back('{OP_TINT, 32'hffff_ff01, 32'h0000_0000});
        pending_reqs.push_back('{OP_TINT, 32'h8000_0000, 32'h1234_5678});
        pending_reqs.push_back('{OP_INC, 32'h7fff_ffff, 32'h0000_0000});
        pending_reqs.push_back('{OP_DEC, 32'h8000_0000, 32'hffff_ffff});
        wait_all_done();

        for (int i = 0; i < 1400; i++) begin
            alu_req_t r;
            r.op = t_op'($urandom_range(15));
            r.a  = pick_operand();
            case ($urandom_range(9))
                0: r.b = 32'h0;
                1: r.b = r.a;
                default: r.b = pick_operand();
            endcase
            pending_reqs.push_back(r);
        end
        wait_all_done();
        repeat (60) @(posedge i_clk);

        $display("Sent %0d requests covering all sixteen operations; %0d results checked.",
                 n_sent, n_checked);
        if (n_errors == 0 && awaited_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Timed out with %0d results outstanding.", awaited_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== fixed_point_alu_q24_8.f =====
rtl/core/fxalu_pkg.sv
rtl/core/fxalu_if.sv
rtl/core/fxalu_front.sv
rtl/core/fxalu_queue.sv
rtl/core/fxalu_back.sv
rtl/core/fixed_point_alu_q24_8.sv
verif/fixed_point_alu_q24_8_tb.sv
